// ===== rtl/elevator_request_controller_core_macros.svh =====
// Assertion macros used by the top-level RTL.
`ifndef ELEVATOR_REQUEST_CONTROLLER_CORE_MACROS_SVH
`define ELEVATOR_REQUEST_CONTROLLER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define ERC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("erc assertion failed");
`define ERC_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("erc forbidden condition");
`else
`define ERC_ASSERT(lbl, clk, rstn, prop)
`define ERC_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ===== rtl/erc_pkg.sv =====
package erc_pkg;

    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_EXT     = 8'h45;  // 'E'
    localparam logic [7:0] CH_INT     = 8'h49;  // 'I'
    localparam logic [7:0] CH_LED_ON  = 8'h4C;  // 'L'
    localparam logic [7:0] CH_LED_OFF = 8'h44;  // 'D'
    localparam logic [7:0] CH_FLOOR0  = 8'h61;  // 'a'
    localparam logic [7:0] CH_UP      = 8'h73;  // 's'
    localparam logic [7:0] CH_DOWN    = 8'h64;  // 'd'
    localparam logic [7:0] CH_STOP    = 8'h70;  // 'p'
    localparam logic [7:0] CH_OPEN    = 8'h61;  // 'a'
    localparam logic [7:0] CH_CLOSE   = 8'h66;  // 'f'
    localparam logic [7:0] UNIT_RESET = 8'h65;  // 'e'

    // command slots, emitted lowest first
    localparam int CMD_N       = 6;
    localparam int CMD_LED_ON  = 0;
    localparam int CMD_MOVE    = 1;
    localparam int CMD_STOP    = 2;
    localparam int CMD_OPEN    = 3;
    localparam int CMD_CLOSE   = 4;
    localparam int CMD_LED_OFF = 5;

    typedef logic [CMD_N-1:0] cmd_mask_t;

    typedef struct packed {
        logic [7:0] kind;
        logic [7:0] arg_a;
        logic [7:0] arg_b;
    } req_t;

    typedef struct packed {
        cmd_mask_t  mask;
        logic [7:0] led_floor;
        logic [7:0] move_char;
        logic [7:0] off_floor;
    } plan_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_stat_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // tens*10 + units in 13-bit two's complement, range -528..2277
    function automatic logic [7:0] floor_letter(input logic [7:0] tens,
                                                input logic [7:0] units);
        logic [12:0] t;
        logic [12:0] n;
        t = {5'd0, tens} - {5'd0, CH_ZERO};
        n = (t << 3) + (t << 1) + {5'd0, units} - {5'd0, CH_ZERO};
        if (!n[12] && (n[11:4] == 8'd0)) begin
            return CH_FLOOR0 + {4'd0, n[3:0]};
        end else begin
            return CH_SPACE;
        end
    endfunction

endpackage

// ===== rtl/erc_queue.sv =====
module erc_queue #(
    parameter int DEPTH = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  erc_pkg::req_t         push_data,
    input  logic                  pop,
    output erc_pkg::req_t         head_data,
    output erc_pkg::queue_stat_t  stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);

    erc_pkg::req_t     mem [DEPTH];
    erc_pkg::req_t     rd_reg;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    always_comb begin
        head_next = head_reg;
        if (pop) begin
            head_next = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
        end
        tail_next = tail_reg;
        if (push) begin
            tail_next = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
        end
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // write-first read of the next head entry
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[tail_reg] <= push_data;
        end
        if (push && (tail_reg == head_next)) begin
            rd_reg <= push_data;
        end else begin
            rd_reg <= mem[head_next];
        end
    end

    assign head_data  = rd_reg;
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_W'(DEPTH));

endmodule

// ===== rtl/erc_ctrl.sv =====
module erc_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_unit_byte,
    input  logic [7:0]            s_kind_byte,
    input  logic [7:0]            s_arg_byte_a,
    input  logic [7:0]            s_arg_byte_b,
    input  logic [7:0]            unit_letter,
    input  logic                  plan_free,
    output logic                  plan_load,
    output erc_pkg::plan_t        plan,
    output logic                  q_push,
    output erc_pkg::req_t         q_push_data,
    output logic                  q_pop,
    input  erc_pkg::req_t         q_head_data,
    input  erc_pkg::queue_stat_t  q_stat
);

    logic           in_valid_reg, in_valid_next;
    logic [7:0]     in_unit_reg;
    erc_pkg::req_t  in_req_reg;

    logic [7:0]     cur_reg, cur_next;
    logic [7:0]     target_reg, target_next;
    logic           active_reg, active_next;
    logic           moving_reg, moving_next;
    erc_pkg::req_t  act_req_reg, act_req_next;

    logic           go;
    logic           handled;
    logic           is_call;
    logic           act_v;
    logic           move;
    logic           arrive;
    logic [7:0]     cur_calc;
    logic [7:0]     target_calc;

    assign go          = in_valid_reg && plan_free;
    assign s_ready     = !in_valid_reg || go;
    assign plan_load   = go;
    assign handled     = go && (in_unit_reg == unit_letter);
    assign q_push_data = in_req_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (go) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        cur_calc = cur_reg;
        if (erc_pkg::is_digit(in_req_reg.kind)) begin
            if (erc_pkg::is_digit(in_req_reg.arg_a)) begin
                cur_calc = erc_pkg::floor_letter(in_req_reg.kind, in_req_reg.arg_a);
            end else begin
                cur_calc = erc_pkg::floor_letter(erc_pkg::CH_ZERO, in_req_reg.kind);
            end
        end

        is_call = (in_req_reg.kind == erc_pkg::CH_EXT) || (in_req_reg.kind == erc_pkg::CH_INT);
        q_push  = handled && is_call && !q_stat.full;
        q_pop   = handled && !active_reg && (!q_stat.empty || q_push);

        act_req_next = act_req_reg;
        if (q_pop) begin
            act_req_next = q_stat.empty ? in_req_reg : q_head_data;
        end
        act_v = active_reg || q_pop;

        target_calc = target_reg;
        if (act_v) begin
            if (act_req_next.kind == erc_pkg::CH_EXT) begin
                target_calc = erc_pkg::floor_letter(act_req_next.arg_a, act_req_next.arg_b);
            end else if (act_req_next.kind == erc_pkg::CH_INT) begin
                target_calc = act_req_next.arg_a;
            end
        end

        move   = !moving_reg && (target_calc != cur_calc);
        arrive = act_v && (target_calc == cur_calc);

        cur_next    = cur_reg;
        target_next = target_reg;
        active_next = active_reg;
        moving_next = moving_reg;
        if (handled) begin
            cur_next    = cur_calc;
            target_next = target_calc;
            active_next = act_v && !arrive;
            moving_next = !arrive && (moving_reg || move);
        end

        plan.mask                       = '0;
        plan.mask[erc_pkg::CMD_LED_ON]  = q_push && (in_req_reg.kind == erc_pkg::CH_INT);
        plan.mask[erc_pkg::CMD_MOVE]    = handled && move;
        plan.mask[erc_pkg::CMD_STOP]    = handled && arrive;
        plan.mask[erc_pkg::CMD_OPEN]    = handled && arrive;
        plan.mask[erc_pkg::CMD_CLOSE]   = handled && arrive;
        plan.mask[erc_pkg::CMD_LED_OFF] = handled && arrive;
        plan.led_floor = in_req_reg.arg_a;
        plan.move_char = (target_calc > cur_calc) ? erc_pkg::CH_UP : erc_pkg::CH_DOWN;
        plan.off_floor = target_calc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            cur_reg      <= erc_pkg::CH_FLOOR0;
            target_reg   <= erc_pkg::CH_FLOOR0;
            active_reg   <= 1'b0;
            moving_reg   <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            cur_reg      <= cur_next;
            target_reg   <= target_next;
            active_reg   <= active_next;
            moving_reg   <= moving_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_unit_reg      <= s_unit_byte;
            in_req_reg.kind  <= s_kind_byte;
            in_req_reg.arg_a <= s_arg_byte_a;
            in_req_reg.arg_b <= s_arg_byte_b;
        end
        act_req_reg <= act_req_next;
    end

endmodule

// ===== rtl/erc_emit.sv =====
module erc_emit (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            load,
    input  erc_pkg::plan_t  plan,
    input  logic [7:0]      unit_letter,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_last_byte,
    output logic            plan_free
);

    localparam logic [1:0] BYTE_UNIT = 2'd0;
    localparam logic [1:0] BYTE_CMD  = 2'd1;
    localparam logic [1:0] BYTE_ARG  = 2'd2;
    localparam logic [1:0] BYTE_END  = 2'd3;

    erc_pkg::cmd_mask_t  mask_reg, mask_next;
    logic [1:0]          idx_reg, idx_next;
    logic [7:0]          led_floor_reg;
    logic [7:0]          move_char_reg;
    logic [7:0]          off_floor_reg;

    erc_pkg::cmd_mask_t  low;
    erc_pkg::cmd_mask_t  rest;
    logic [7:0]          cmd_char;
    logic [7:0]          arg_char;
    logic                fire;

    assign low       = mask_reg & (~mask_reg + 1'b1);
    assign rest      = mask_reg & ~low;
    assign m_valid   = (mask_reg != '0);
    assign fire      = m_valid && m_ready;
    assign m_last_byte = (idx_reg == BYTE_END) && (rest == '0);
    assign plan_free = !m_valid || (fire && m_last_byte);

    always_comb begin
        arg_char = erc_pkg::CH_LF;
        if (low[erc_pkg::CMD_LED_ON]) begin
            cmd_char = erc_pkg::CH_LED_ON;
            arg_char = led_floor_reg;
        end else if (low[erc_pkg::CMD_MOVE]) begin
            cmd_char = move_char_reg;
        end else if (low[erc_pkg::CMD_STOP]) begin
            cmd_char = erc_pkg::CH_STOP;
        end else if (low[erc_pkg::CMD_OPEN]) begin
            cmd_char = erc_pkg::CH_OPEN;
        end else if (low[erc_pkg::CMD_CLOSE]) begin
            cmd_char = erc_pkg::CH_CLOSE;
        end else begin
            cmd_char = erc_pkg::CH_LED_OFF;
            arg_char = off_floor_reg;
        end

        case (idx_reg)
            BYTE_UNIT: m_out_byte = unit_letter;
            BYTE_CMD:  m_out_byte = cmd_char;
            BYTE_ARG:  m_out_byte = arg_char;
            default:   m_out_byte = erc_pkg::CH_CR;
        endcase
    end

    always_comb begin
        mask_next = mask_reg;
        idx_next  = idx_reg;
        if (load) begin
            mask_next = plan.mask;
            idx_next  = BYTE_UNIT;
        end else if (fire) begin
            idx_next = idx_reg + 1'b1;
            if (idx_reg == BYTE_END) begin
                mask_next = rest;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
            idx_reg  <= BYTE_UNIT;
        end else begin
            mask_reg <= mask_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            led_floor_reg <= plan.led_floor;
            move_char_reg <= plan.move_char;
            off_floor_reg <= plan.off_floor;
        end
    end

endmodule

// ===== rtl/elevator_request_controller_core.sv =====
// Channel   Handshake          Payload
// s_        s_valid/s_ready    s_unit_byte, s_kind_byte, s_arg_byte_a, s_arg_byte_b
// m_        m_valid/m_ready    m_out_byte, m_last_byte
// cfg_      cfg_wr_en          cfg_wr_data (unit letter)
//
// An item is registered, then decoded combinationally against the car state and queue.
// Its commands leave one byte per cycle while m_ready is high: 0 to 20 bytes, sent by
// the byte serializer. One further item waits in the input register meanwhile.
// Queue head is read from a registered memory port, prefetched each cycle.
// Synchronous active-low reset; no clearing pass, queue entries are never read unwritten.
`include "elevator_request_controller_core_macros.svh"

module elevator_request_controller_core #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_unit_byte,
    input  logic [7:0]  s_kind_byte,
    input  logic [7:0]  s_arg_byte_a,
    input  logic [7:0]  s_arg_byte_b,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_last_byte,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data
);

    logic [7:0]            unit_letter_reg;
    logic                  plan_free;
    logic                  plan_load;
    erc_pkg::plan_t        plan;
    logic                  q_push;
    logic                  q_pop;
    erc_pkg::req_t         q_push_data;
    erc_pkg::req_t         q_head_data;
    erc_pkg::queue_stat_t  q_stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_letter_reg <= erc_pkg::UNIT_RESET;
        end else if (cfg_wr_en) begin
            unit_letter_reg <= cfg_wr_data;
        end
    end

    erc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .head_data (q_head_data),
        .stat      (q_stat)
    );

    erc_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_unit_byte  (s_unit_byte),
        .s_kind_byte  (s_kind_byte),
        .s_arg_byte_a (s_arg_byte_a),
        .s_arg_byte_b (s_arg_byte_b),
        .unit_letter  (unit_letter_reg),
        .plan_free    (plan_free),
        .plan_load    (plan_load),
        .plan         (plan),
        .q_push       (q_push),
        .q_push_data  (q_push_data),
        .q_pop        (q_pop),
        .q_head_data  (q_head_data),
        .q_stat       (q_stat)
    );

    erc_emit u_emit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (plan_load),
        .plan        (plan),
        .unit_letter (unit_letter_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_last_byte (m_last_byte),
        .plan_free   (plan_free)
    );

    `ERC_ASSERT_NEVER(a_push_full, aclk, aresetn, q_push && q_stat.full)
    `ERC_ASSERT_NEVER(a_pop_empty, aclk, aresetn, q_pop && q_stat.empty && !q_push)
    `ERC_ASSERT_NEVER(a_load_busy, aclk, aresetn, plan_load && m_valid && !(m_ready && m_last_byte))
    `ERC_ASSERT(a_push_count, aclk, aresetn, (q_push && !q_pop) |=> !q_stat.empty)

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

typedef struct packed {
    logic [7:0] kind;
    logic [7:0] arg_a;
    logic [7:0] arg_b;
} call_t;

typedef struct packed {
    logic [7:0] ch;
    logic       last;
} out_char_t;

class elevator_scoreboard;
    localparam int QDEPTH = 64;

    logic [7:0]  unit_letter = erc_pkg::UNIT_RESET;
    logic [7:0]  cur_floor = erc_pkg::CH_FLOOR0;
    logic [7:0]  tgt_floor = erc_pkg::CH_FLOOR0;
    call_t       active_call = '0;
    bit          active_valid = 0;
    bit          moving = 0;
    call_t       call_q[$];
    out_char_t   out_q[$];
    int          errors = 0;

    function bit is_num(logic [7:0] c);
        return c >= erc_pkg::CH_ZERO && c <= erc_pkg::CH_NINE;
    endfunction

    function logic [7:0] floor_code(logic [7:0] tens, logic [7:0] units);
        int n;
        n = (int'(tens) - int'(erc_pkg::CH_ZERO)) * 10
            + (int'(units) - int'(erc_pkg::CH_ZERO));
        return (n >= 0 && n <= 15) ? erc_pkg::CH_FLOOR0 + 8'(n) : erc_pkg::CH_SPACE;
    endfunction

    function void push_line(logic [7:0] cmd, logic [7:0] third);
        out_q.push_back({unit_letter, 1'b0});
        out_q.push_back({cmd, 1'b0});
        out_q.push_back({third, 1'b0});
        out_q.push_back({erc_pkg::CH_CR, 1'b0});
    endfunction

    // floor number that makes the current target reachable by a floor report
    function int target_number();
        if (tgt_floor >= erc_pkg::CH_FLOOR0 && tgt_floor <= erc_pkg::CH_FLOOR0 + 8'd15)
            return int'(tgt_floor - erc_pkg::CH_FLOOR0);
        return 50;
    endfunction

    function int pending();
        return out_q.size();
    endfunction

    function void note_item(logic [7:0] u, logic [7:0] k, logic [7:0] a, logic [7:0] b);
        int n_before;
        n_before = out_q.size();
        if (u != unit_letter)
            return;
        if (is_num(k))
            cur_floor = is_num(a) ? floor_code(k, a) : floor_code(erc_pkg::CH_ZERO, k);
        if ((k == erc_pkg::CH_EXT || k == erc_pkg::CH_INT) && call_q.size() < QDEPTH) begin
            if (k == erc_pkg::CH_INT)
                push_line(erc_pkg::CH_LED_ON, a);
            call_q.push_back({k, a, b});
        end
        if (!active_valid && call_q.size() > 0) begin
            active_call = call_q.pop_front();
            active_valid = 1;
        end
        if (active_valid) begin
            if (active_call.kind == erc_pkg::CH_EXT)
                tgt_floor = floor_code(active_call.arg_a, active_call.arg_b);
            else if (active_call.kind == erc_pkg::CH_INT)
                tgt_floor = active_call.arg_a;
        end
        if (!moving && tgt_floor > cur_floor) begin
            push_line(erc_pkg::CH_UP, erc_pkg::CH_LF);
            moving = 1;
        end else if (!moving && tgt_floor < cur_floor) begin
            push_line(erc_pkg::CH_DOWN, erc_pkg::CH_LF);
            moving = 1;
        end
        if (tgt_floor == cur_floor && active_valid) begin
            push_line(erc_pkg::CH_STOP, erc_pkg::CH_LF);
            push_line(erc_pkg::CH_OPEN, erc_pkg::CH_LF);
            push_line(erc_pkg::CH_CLOSE, erc_pkg::CH_LF);
            push_line(erc_pkg::CH_LED_OFF, tgt_floor);
            active_valid = 0;
            active_call = '0;
            moving = 0;
        end
        if (out_q.size() > n_before)
            out_q[out_q.size() - 1].last = 1'b1;
    endfunction

    function void check_result(logic [7:0] ch, logic last);
        out_char_t exp_c;
        if (out_q.size() == 0) begin
            $display("%0t: unexpected item byte %02h last %0b", $time, ch, last);
            errors++;
            return;
        end
        exp_c = out_q.pop_front();
        if (ch !== exp_c.ch) begin
            $display("%0t: out_byte expected %02h actual %02h", $time, exp_c.ch, ch);
            errors++;
        end
        if (last !== exp_c.last) begin
            $display("%0t: last_byte expected %0b actual %0b", $time, exp_c.last, last);
            errors++;
        end
    endfunction
endclass

module testbench;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 40;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_unit_byte;
    logic [7:0] s_kind_byte;
    logic [7:0] s_arg_byte_a;
    logic [7:0] s_arg_byte_b;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_out_byte;
    logic       m_last_byte;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;

    int idle_pct = 9;
    int stall_pct = 9;
    int cycles = 0;
    elevator_scoreboard sb;

    elevator_request_controller_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_unit_byte  (s_unit_byte),
        .s_kind_byte  (s_kind_byte),
        .s_arg_byte_a (s_arg_byte_a),
        .s_arg_byte_b (s_arg_byte_b),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_last_byte  (m_last_byte),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid && m_ready)
            sb.check_result(m_out_byte, m_last_byte);
    end

    always @(posedge aclk) begin
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_item(input logic [7:0] u, input logic [7:0] k,
                             input logic [7:0] a, input logic [7:0] b);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_unit_byte  <= u;
        s_kind_byte  <= k;
        s_arg_byte_a <= a;
        s_arg_byte_b <= b;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(u, k, a, b);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_unit(input logic [7:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.unit_letter = v;
    endtask

    // call_pct: share of calls, mostly well-formed; the rest is mostly floor reports
    task automatic run_phase(input int n_items, input int call_pct);
        int handled;
        int r;
        int fl;
        logic [7:0] u, k, a, b;
        handled = 0;
        while (handled < n_items) begin
            r = $urandom_range(99);
            u = sb.unit_letter;
            k = 8'($urandom);
            a = 8'($urandom);
            b = 8'($urandom);
            if (r < 8) begin
                if (r < 4)
                    u = 8'($urandom);
                // keep the active target reachable
                if (k == erc_pkg::CH_INT)
                    a = erc_pkg::CH_FLOOR0;
            end else if (r < 8 + call_pct) begin
                if ($urandom_range(1)) begin
                    k = erc_pkg::CH_INT;
                    a = ($urandom_range(9) == 0)
                        ? erc_pkg::CH_SPACE
                        : erc_pkg::CH_FLOOR0 + 8'($urandom_range(15));
                end else begin
                    k = erc_pkg::CH_EXT;
                    fl = $urandom_range(15);
                    if ($urandom_range(9) == 0)
                        fl = $urandom_range(99);
                    a = erc_pkg::CH_ZERO + 8'(fl / 10);
                    b = erc_pkg::CH_ZERO + 8'(fl % 10);
                    if ($urandom_range(19) == 0) begin
                        a = 8'($urandom);
                        b = 8'($urandom);
                    end
                end
            end else begin
                fl = $urandom_range(15);
                if ($urandom_range(9) == 0)
                    fl = $urandom_range(99, 16);
                if ($urandom_range(1))
                    fl = sb.target_number();
                if (fl < 10 && $urandom_range(1)) begin
                    k = erc_pkg::CH_ZERO + 8'(fl);
                    if (a >= erc_pkg::CH_ZERO && a <= erc_pkg::CH_NINE)
                        a = erc_pkg::CH_CR;
                end else begin
                    k = erc_pkg::CH_ZERO + 8'(fl / 10);
                    a = erc_pkg::CH_ZERO + 8'(fl % 10);
                end
            end
            if (u == sb.unit_letter)
                handled++;
            send_item(u, k, a, b);
        end
    endtask

    initial begin
        sb = new();
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_unit_byte  <= 8'h00;
        s_kind_byte  <= 8'h00;
        s_arg_byte_a <= 8'h00;
        s_arg_byte_b <= 8'h00;
        m_ready      <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_wr_data  <= 8'h00;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, reset unit letter
        send_item(erc_pkg::UNIT_RESET ^ 8'h01, erc_pkg::CH_INT,
                  erc_pkg::CH_FLOOR0 + 8'd2, 8'h00);
        send_item(erc_pkg::UNIT_RESET, erc_pkg::CH_ZERO + 8'd5,
                  erc_pkg::CH_CR, 8'h00);                  // move from stale target
        send_item(erc_pkg::UNIT_RESET, erc_pkg::CH_ZERO, erc_pkg::CH_ZERO, 8'h00);
        send_item(erc_pkg::UNIT_RESET, erc_pkg::CH_INT, erc_pkg::CH_FLOOR0 + 8'd3, 8'hFF);
        send_item(erc_pkg::UNIT_RESET, erc_pkg::CH_ZERO + 8'd3, 8'hFF, 8'h00);
        send_item(erc_pkg::UNIT_RESET, erc_pkg::CH_INT,
                  erc_pkg::CH_FLOOR0 + 8'd3, 8'h00);       // led on plus arrival
        send_item(erc_pkg::UNIT_RESET, erc_pkg::CH_EXT,
                  erc_pkg::CH_ZERO + 8'd1, erc_pkg::CH_ZERO + 8'd5);
        send_item(erc_pkg::UNIT_RESET, erc_pkg::CH_ZERO + 8'd1,
                  erc_pkg::CH_ZERO + 8'd5, 8'h00);
        send_item(erc_pkg::UNIT_RESET, erc_pkg::CH_EXT, erc_pkg::CH_NINE, erc_pkg::CH_NINE);
        send_item(erc_pkg::UNIT_RESET, erc_pkg::CH_ZERO + 8'd1,
                  erc_pkg::CH_ZERO + 8'd6, 8'h00);
        send_item(erc_pkg::UNIT_RESET, erc_pkg::CH_EXT, 8'hFF, 8'h00);
        send_item(erc_pkg::UNIT_RESET, erc_pkg::CH_ZERO, erc_pkg::CH_NINE, 8'h00);
        send_item(erc_pkg::UNIT_RESET, erc_pkg::CH_INT, erc_pkg::CH_SPACE, 8'h00);
        send_item(erc_pkg::UNIT_RESET, erc_pkg::CH_INT, erc_pkg::CH_FLOOR0 + 8'd15, 8'h00);
        send_item(erc_pkg::UNIT_RESET, erc_pkg::CH_EXT,
                  erc_pkg::CH_ZERO - 8'd1, erc_pkg::CH_ZERO);
        send_item(erc_pkg::UNIT_RESET, 8'h00, 8'h00, 8'h00);
        send_item(erc_pkg::UNIT_RESET, erc_pkg::CH_NINE, 8'hFF, 8'hFF);
        send_item(erc_pkg::UNIT_RESET, erc_pkg::CH_ZERO + 8'd5, erc_pkg::CH_ZERO, 8'h00);
        send_item(erc_pkg::UNIT_RESET, erc_pkg::CH_ZERO + 8'd1,
                  erc_pkg::CH_ZERO + 8'd5, 8'h00);
        send_item(erc_pkg::UNIT_RESET, erc_pkg::CH_ZERO, erc_pkg::CH_CR, 8'h00);
        send_item(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        settle();

        write_unit(8'h00);
        run_phase(40, 30);
        settle();

        idle_pct  = 0;
        stall_pct = 0;
        write_unit(8'hFF);
        run_phase(30, 30);
        settle();
        idle_pct  = 9;
        stall_pct = 9;

        // fill the call queue past full, then work it off
        write_unit(erc_pkg::UNIT_RESET);
        run_phase(100, 85);
        run_phase(60, 5);
        settle();

        write_unit(8'($urandom_range(255)));
        run_phase(40, 30);
        settle();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
